>>> src/mltx_pkg.sv
`default_nettype none

package mltx_pkg;

    // Default frame length in bits after the start bit
    localparam int FRAME_BITS_DEF = 16;

    // Register reset values
    localparam logic [15:0] HALF_BIT_TICKS_RST = 16'd416;
    localparam logic [15:0] GAP_TICKS_RST      = 16'd6000;

    // Addressed frame: largest short address and group flag position
    localparam logic [7:0] ADDR_MAX   = 8'h3F;
    localparam logic [7:0] GROUP_MASK = 8'h80;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_HALF_BIT_TICKS = 2'd0,
        REG_GAP_TICKS      = 2'd1,
        REG_TX_ACTIVE_LOW  = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

    // Request kinds
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_ADDRESSED = 2'd1,
        CMD_RAW       = 2'd2,
        CMD_RESERVED  = 2'd3
    } cmd_t;

    // Request outcome
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [15:0] gap_ticks;
        logic        tx_active_low;
    } cfg_t;

    typedef struct packed {
        logic    tx_level;
        logic    busy_res;
        status_t status;
    } result_t;

endpackage

`default_nettype wire

>>> src/manchester_lighting_frame_tx.sv
// Manchester transmitter for two-byte lighting-bus forward frames. Each input
// transfer is one time-base tick and may carry a send request; each one yields
// exactly one result transfer with the line level, busy flag and request
// status for that tick. One tick is taken every clock cycle while the skid
// entry is empty: the encoder updates its frame state in a single pass from
// the input and its state registers, and the result is registered in an
// output register backed by a skid entry, so input stays ready while one
// result waits. A frame is a start bit followed by FRAME_BITS bits, MSB
// first; each half-bit lasts half_bit_ticks ticks (at least one) and the
// line then idles for gap_ticks ticks with busy held. Configuration must be
// written through the register port between transfers, which the block does
// not enforce, and applies from the next tick, also in the middle of a frame.
`default_nettype none

module manchester_lighting_frame_tx #(
    parameter int FRAME_BITS = mltx_pkg::FRAME_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // tick and request input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // group_flag[0], short_address[8:1], command_flag[9],
    // raw_first_byte[17:10], data_byte[25:18], zero [31:26]
    input  wire logic [31:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    // per-tick result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tx_level[0], busy_res[1], zero [7:2]
    output logic [7:0]       m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser
);

    mltx_pkg::cfg_t     cfg;
    mltx_pkg::result_t  core_res;
    mltx_pkg::result_t  out_res;
    logic               in_accept;

    assign in_accept = s_tvalid & s_tready;

    mltx_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mltx_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .in_accept      (in_accept),
        .cmd            (s_tuser),
        .group_flag     (s_tdata[0]),
        .short_address  (s_tdata[8:1]),
        .command_flag   (s_tdata[9]),
        .raw_first_byte (s_tdata[17:10]),
        .data_byte      (s_tdata[25:18]),
        .res            (core_res)
    );

    mltx_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {6'b0, out_res.busy_res, out_res.tx_level};
    assign m_tuser = out_res.status;

endmodule

`default_nettype wire

>>> src/mltx_cfg.sv
`default_nettype none

module mltx_cfg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    output mltx_pkg::cfg_t          cfg
);

    mltx_pkg::cfg_t cfg_reg;

    // Register file; writes to an unused index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_bit_ticks <= mltx_pkg::HALF_BIT_TICKS_RST;
            cfg_reg.gap_ticks      <= mltx_pkg::GAP_TICKS_RST;
            cfg_reg.tx_active_low  <= 1'b0;
        end else if (cfg_we) begin
            unique case (mltx_pkg::reg_index_t'(cfg_index))
                mltx_pkg::REG_HALF_BIT_TICKS: cfg_reg.half_bit_ticks <= cfg_wdata;
                mltx_pkg::REG_GAP_TICKS:      cfg_reg.gap_ticks      <= cfg_wdata;
                mltx_pkg::REG_TX_ACTIVE_LOW:  cfg_reg.tx_active_low  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/mltx_core.sv
`default_nettype none

module mltx_core #(
    parameter int FRAME_BITS = mltx_pkg::FRAME_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mltx_pkg::cfg_t     cfg,
    input  wire logic               in_accept,
    input  wire logic [1:0]         cmd,
    input  wire logic               group_flag,
    input  wire logic [7:0]         short_address,
    input  wire logic               command_flag,
    input  wire logic [7:0]         raw_first_byte,
    input  wire logic [7:0]         data_byte,
    output mltx_pkg::result_t       res
);

    localparam int SHIFT_W = FRAME_BITS + 1;
    localparam int BL_W    = $clog2(FRAME_BITS + 2);
    localparam int IDX_W   = $clog2(SHIFT_W);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEND = 2'd1,
        MODE_GAP  = 2'd2
    } mode_t;

    mode_t               mode_reg,   mode_next;
    logic [SHIFT_W-1:0]  shift_reg,  shift_next;
    logic [BL_W-1:0]     bits_reg,   bits_next;
    logic                half_reg,   half_next;
    logic [15:0]         count_reg,  count_next;

    mltx_pkg::cmd_t      cmd_kind;
    logic [7:0]          first_byte;
    logic [31:0]         word_wide;
    logic [BL_W-1:0]     bit_pos;
    logic                cur_bit;
    logic [16:0]         count_inc;
    logic                idle_level;

    assign cmd_kind   = mltx_pkg::cmd_t'(cmd);
    assign idle_level = ~cfg.tx_active_low;
    assign first_byte = (cmd_kind == mltx_pkg::CMD_ADDRESSED)
                      ? ({group_flag, 7'b0} & mltx_pkg::GROUP_MASK)
                        | {1'b0, short_address[5:0], command_flag}
                      : raw_first_byte;
    assign word_wide  = {16'b0, first_byte, data_byte};

    // One tick: request decode, then advance the half-bit or gap timer
    always_comb begin
        mode_next  = mode_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        half_next  = half_reg;
        count_next = count_reg;
        res.status   = mltx_pkg::ST_NONE;
        res.tx_level = idle_level;
        res.busy_res = 1'b0;
        cur_bit      = 1'b0;
        bit_pos      = '0;
        count_inc    = '0;

        // unknown mode code falls back to idle
        unique case (mode_reg)
            MODE_SEND, MODE_GAP: ;
            default: mode_next = MODE_IDLE;
        endcase

        if (cmd_kind == mltx_pkg::CMD_ADDRESSED || cmd_kind == mltx_pkg::CMD_RAW) begin
            priority if (mode_next != MODE_IDLE) begin
                res.status = mltx_pkg::ST_BUSY;
            end else if (cmd_kind == mltx_pkg::CMD_ADDRESSED
                         && short_address > mltx_pkg::ADDR_MAX) begin
                res.status = mltx_pkg::ST_BAD_ADDR;
            end else begin
                shift_next = {1'b1, word_wide[FRAME_BITS-1:0]};
                bits_next  = BL_W'(FRAME_BITS + 1);
                half_next  = 1'b0;
                count_next = '0;
                mode_next  = MODE_SEND;
                res.status = mltx_pkg::ST_ACCEPTED;
            end
        end

        unique case (mode_next)
            MODE_SEND: begin
                bit_pos = bits_next - BL_W'(1);
                if (bits_next != '0 && bits_next <= BL_W'(FRAME_BITS + 1)) begin
                    cur_bit = shift_next[bit_pos[IDX_W-1:0]];
                end
                // a one is low then high before inversion
                res.tx_level = (half_next ? cur_bit : ~cur_bit) ^ cfg.tx_active_low;
                res.busy_res = 1'b1;
                count_inc    = {1'b0, count_next} + 17'd1;
                count_next   = count_inc[15:0];
                if (count_inc >= {1'b0, cfg.half_bit_ticks}) begin
                    count_next = '0;
                    if (half_next) begin
                        half_next = 1'b0;
                        if (bits_next != '0) begin
                            bits_next = bits_next - BL_W'(1);
                        end
                        if (bits_next == '0) begin
                            mode_next = (cfg.gap_ticks == '0) ? MODE_IDLE : MODE_GAP;
                        end
                    end else begin
                        half_next = 1'b1;
                    end
                end
            end
            MODE_GAP: begin
                res.busy_res = 1'b1;
                count_inc    = {1'b0, count_next} + 17'd1;
                count_next   = count_inc[15:0];
                if (count_inc >= {1'b0, cfg.gap_ticks}) begin
                    count_next = '0;
                    mode_next  = MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Frame state advances once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            shift_reg <= '0;
            bits_reg  <= '0;
            half_reg  <= 1'b0;
            count_reg <= '0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            half_reg  <= half_next;
            count_reg <= count_next;
        end
    end

    // A busy rejection can only happen while the line is in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && res.status == mltx_pkg::ST_BUSY |-> res.busy_res)
        else $error("busy rejection reported on a free line");

    // An accepted request drives the first half of the start bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && res.status == mltx_pkg::ST_ACCEPTED
        |-> res.busy_res && (res.tx_level == cfg.tx_active_low))
        else $error("accepted frame did not start with the start bit");

endmodule

`default_nettype wire

>>> src/mltx_obuf.sv
`default_nettype none

module mltx_obuf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mltx_pkg::result_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mltx_pkg::result_t       out_data
);

    logic               main_valid_reg;
    logic               skid_valid_reg;
    mltx_pkg::result_t  main_reg;
    mltx_pkg::result_t  skid_reg;
    logic               push;
    logic               pop;

    assign in_ready  = ~skid_valid_reg;
    assign push      = in_valid & in_ready;
    assign pop       = main_valid_reg & out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Output register backed by one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg       <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Skid entry is only used behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    // A stalled full buffer keeps both entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !out_ready |=> skid_valid_reg && main_valid_reg)
        else $error("result lost while output stalled");

    // An accepted item always leaves a result behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> main_valid_reg)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire
